>>> hw/rtl/photon_time_binner_top_macros.svh
// Assertion macros used by the checker file.
`ifndef PHOTON_TIME_BINNER_TOP_MACROS_SVH
`define PHOTON_TIME_BINNER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ptb_pkg.sv
package ptb_pkg;

    localparam int TIME_W            = 64;
    localparam int COUNT_W           = 16;
    localparam int MAX_EMPTY_RUN_DEF = 63;
    localparam int QUEUE_DEPTH_DEF   = 2;

    typedef logic [TIME_W-1:0]  stamp_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [0:0]         cfg_idx_t;

    localparam count_t   COUNT_MAX       = '1;
    localparam stamp_t   BIN_LENGTH_RST  = 64'd1000;
    localparam cfg_idx_t REG_BIN_LENGTH  = 1'b0;
    localparam cfg_idx_t REG_SKIP_EMPTY  = 1'b1;

    // One bin change handed from the front to the back
    typedef struct packed {
        stamp_t arrival;
        stamp_t cur_start;
        count_t cur_count;
        stamp_t bin_len;
        logic   skip;
    } job_t;

    // Aligned start of the new bin, returned to the front
    typedef struct packed {
        logic   valid;
        stamp_t new_start;
    } done_t;

endpackage

>>> hw/rtl/ptb_front.sv
module ptb_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  ptb_pkg::cfg_idx_t cfg_index,
    input  ptb_pkg::stamp_t   cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  ptb_pkg::stamp_t   arrival_time,
    input  logic              q_full,
    output logic              q_push,
    output ptb_pkg::job_t     q_job,
    input  ptb_pkg::done_t    done
);
    import ptb_pkg::*;

    stamp_t bin_len_reg;
    logic   skip_reg;
    stamp_t start_reg;
    count_t count_reg;
    logic   first_seen_reg;
    logic   wait_reg;

    stamp_t len_eff;
    logic   accept;
    logic   is_close;

    assign len_eff  = (bin_len_reg == '0) ? TIME_W'(1) : bin_len_reg;
    assign in_stall = wait_reg || q_full;
    assign accept   = in_valid && !in_stall;
    // a bin end past 2^64-1 never closes: compare the distance, not the end
    assign is_close = first_seen_reg && (arrival_time >= start_reg)
                      && ((arrival_time - start_reg) >= len_eff);

    assign q_push = accept && is_close;
    assign q_job  = '{arrival:   arrival_time,
                      cur_start: start_reg,
                      cur_count: count_reg,
                      bin_len:   len_eff,
                      skip:      skip_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_len_reg    <= BIN_LENGTH_RST;
            skip_reg       <= 1'b0;
            start_reg      <= '0;
            count_reg      <= '0;
            first_seen_reg <= 1'b0;
            wait_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BIN_LENGTH: bin_len_reg <= cfg_data;
                    REG_SKIP_EMPTY: skip_reg    <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (done.valid)
            begin
                start_reg <= done.new_start;
                count_reg <= count_t'(1);
                wait_reg  <= 1'b0;
            end
            else if (accept)
            begin
                if (!first_seen_reg)
                begin
                    start_reg      <= arrival_time;
                    count_reg      <= count_t'(1);
                    first_seen_reg <= 1'b1;
                end
                else if (is_close)
                begin
                    // hold further beats until the back returns the new start
                    wait_reg <= 1'b1;
                end
                else if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + count_t'(1);
                end
            end
        end
    end

endmodule

>>> hw/rtl/ptb_fifo.sv
module ptb_fifo
#(
    parameter int DEPTH = ptb_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ptb_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output ptb_pkg::job_t pop_data
);
    import ptb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic do_push;
    logic do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/ptb_back.sv
module ptb_back
#(
    parameter int MAX_EMPTY_RUN = ptb_pkg::MAX_EMPTY_RUN_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ptb_pkg::job_t   q_job,
    output logic            q_pop,
    output ptb_pkg::done_t  done,
    output logic            out_valid,
    input  logic            out_stall,
    output ptb_pkg::stamp_t bin_time,
    output ptb_pkg::count_t photon_count,
    output logic            last_of_run,
    output logic            gap_truncated
);
    import ptb_pkg::*;

    localparam int RUN_W = $clog2(MAX_EMPTY_RUN + 1);
    localparam int BIT_W = $clog2(TIME_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_GAP   = 3'd4;

    logic [2:0]       state_reg;
    logic             out_valid_reg;
    job_t             job_reg;
    stamp_t           rem_reg;
    stamp_t           dvd_reg;
    logic [BIT_W-1:0] bit_cnt_reg;
    stamp_t           new_start_reg;
    stamp_t           gap_reg;
    logic [RUN_W-1:0] run_reg;
    stamp_t           bin_time_reg;
    count_t           count_reg;
    logic             last_reg;
    logic             trunc_reg;

    logic [TIME_W:0]  rem_shift;
    logic             rem_ge;
    stamp_t           rem_next;
    logic [TIME_W:0]  gap_sum;
    logic             gap_more_next;
    logic [RUN_W-1:0] run_next;
    logic             close_more;
    logic             slot_free;
    logic             close_last;
    logic             gap_last;
    logic             emit;

    // restoring division, one quotient bit per cycle; only the remainder is kept
    assign rem_shift = {rem_reg, dvd_reg[TIME_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, job_reg.bin_len});
    assign rem_next  = rem_ge ? TIME_W'(rem_shift - {1'b0, job_reg.bin_len})
                              : rem_shift[TIME_W-1:0];

    // stop the gap run when the next bin start would wrap past 64 bits
    assign gap_sum       = {1'b0, gap_reg} + {1'b0, job_reg.bin_len};
    assign gap_more_next = !gap_sum[TIME_W] && (gap_sum[TIME_W-1:0] < new_start_reg);
    assign run_next      = run_reg + RUN_W'(1);
    assign gap_last      = !gap_more_next || (run_next == RUN_W'(MAX_EMPTY_RUN));

    assign close_more = (gap_reg < new_start_reg);
    assign close_last = job_reg.skip || !close_more;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign emit       = ((state_reg == S_CLOSE) || (state_reg == S_GAP)) && slot_free;

    assign q_pop          = (state_reg == S_IDLE) && q_valid;
    assign done.valid     = (state_reg == S_PREP);
    assign done.new_start = job_reg.arrival - rem_reg;

    assign out_valid     = out_valid_reg;
    assign bin_time      = bin_time_reg;
    assign photon_count  = count_reg;
    assign last_of_run   = last_reg;
    assign gap_truncated = trunc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (bit_cnt_reg == BIT_W'(TIME_W - 1))
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_CLOSE;
                end
                S_CLOSE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= close_last ? S_IDLE : S_GAP;
                    end
                end
                S_GAP:
                begin
                    if (slot_free && gap_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    job_reg     <= q_job;
                    rem_reg     <= '0;
                    dvd_reg     <= q_job.arrival;
                    bit_cnt_reg <= '0;
                end
            end
            S_DIV:
            begin
                rem_reg     <= rem_next;
                dvd_reg     <= {dvd_reg[TIME_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
            end
            S_PREP:
            begin
                // new start = arrival - (arrival mod length)
                new_start_reg <= job_reg.arrival - rem_reg;
                gap_reg       <= job_reg.cur_start + job_reg.bin_len;
                run_reg       <= '0;
            end
            S_CLOSE:
            begin
                if (slot_free)
                begin
                    bin_time_reg <= job_reg.cur_start;
                    count_reg    <= job_reg.cur_count;
                    last_reg     <= close_last;
                    trunc_reg    <= 1'b0;
                end
            end
            S_GAP:
            begin
                if (slot_free)
                begin
                    bin_time_reg <= gap_reg;
                    count_reg    <= '0;
                    last_reg     <= gap_last;
                    trunc_reg    <= gap_last && gap_more_next;
                    gap_reg      <= gap_sum[TIME_W-1:0];
                    run_reg      <= run_next;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> hw/rtl/photon_time_binner_top.sv
// Channel | Beat                                                | Handshake
// --------+-----------------------------------------------------+---------------------
// in      | arrival_time                                        | in_valid / in_stall
// out     | bin_time, photon_count, last_of_run, gap_truncated  | out_valid / out_stall
// cfg     | cfg_index, cfg_data                                 | cfg_write
//
// A photon inside the open bin is counted at the edge it is accepted.
// With the back idle, a bin-closing photon stalls the input while it passes the queue,
// the 64 remainder divider steps and the step that returns the new start; then the closed
// bin is offered, followed by one empty bin per cycle while out_stall is low.
// out_stall holds the back; the front keeps counting until the next closing photon.
// Reset clears the bin state, sets a bin length of 1000 and turns skipping off.
module photon_time_binner_top
#(
    parameter int MAX_EMPTY_RUN = ptb_pkg::MAX_EMPTY_RUN_DEF,
    parameter int QUEUE_DEPTH   = ptb_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  ptb_pkg::cfg_idx_t cfg_index,
    input  ptb_pkg::stamp_t   cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  ptb_pkg::stamp_t   arrival_time,
    output logic              out_valid,
    input  logic              out_stall,
    output ptb_pkg::stamp_t   bin_time,
    output ptb_pkg::count_t   photon_count,
    output logic              last_of_run,
    output logic              gap_truncated
);
    import ptb_pkg::*;

    logic  push;
    job_t  push_job;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    job_t  q_job;
    done_t done;

    ptb_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .arrival_time (arrival_time),
        .q_full       (q_full),
        .q_push       (push),
        .q_job        (push_job),
        .done         (done)
    );

    ptb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_job)
    );

    ptb_back #(.MAX_EMPTY_RUN(MAX_EMPTY_RUN)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .q_pop         (q_pop),
        .done          (done),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bin_time      (bin_time),
        .photon_count  (photon_count),
        .last_of_run   (last_of_run),
        .gap_truncated (gap_truncated)
    );

endmodule

>>> hw/rtl/ptb_checker.sv
`include "photon_time_binner_top_macros.svh"

module ptb_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input ptb_pkg::stamp_t   bin_time,
    input ptb_pkg::count_t   photon_count,
    input logic              last_of_run,
    input logic              gap_truncated
);

    // a stalled result beat stays put
    `PTB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bin_time) && $stable(photon_count) && $stable(last_of_run), "stalled result changed")

    // truncation is flagged only on the closing empty bin of a run
    `PTB_ASSERT_NOW(a_trunc_last, out_valid && gap_truncated, last_of_run && (photon_count == '0), "gap flag off an empty final bin")

    // the rest of a run follows without a bubble
    `PTB_ASSERT_NEXT(a_run_cont, out_valid && !out_stall && !last_of_run, out_valid, "gap in a result run")

    // empty bins of a run lie on later starts than the bin before them
    `PTB_ASSERT_NEXT(a_run_order, out_valid && !out_stall && !last_of_run, bin_time > $past(bin_time), "run not ascending")

endmodule

bind photon_time_binner_top ptb_checker u_ptb_checker (.*);
